// ===== design/tpdm_pkg.sv =====
// Package for the phrase-dictionary marker.
// Holds the opcode codes and the command/status structs between controller
// and datapath. No dependencies.
package tpdm_pkg;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_TEXT  = 2'd1,
    OP_END   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef struct packed {
    logic accept;      // take the input word (key load, clear, push, end of text)
    logic key_first;   // restart the key scan at key zero
    logic key_next;    // advance to the next key
    logic tok_first;   // restart the token compare of the current key
    logic tok_next;    // advance to the next token of the current key
    logic tok_hit;     // close the compare, mark the start position on a match
    logic pop;         // emit the oldest window position
  } tpdm_cmd_t;

  typedef struct packed {
    logic has_keys;
    logic len_skip;
    logic key_last;
    logic tok_last;
    logic pop_needed;
    logic flush_needed;
    logic out_free;
  } tpdm_status_t;

endpackage

// ===== design/token_phrase_dictionary_marker_core.sv =====
// Top level of the phrase-dictionary marker.
// Depends on tpdm_pkg, tpdm_ctrl and tpdm_dp.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    opcode, token_value, key_end,
//                                    token_missing, prior_label
//   output    out_valid / out_ready  position_label, text_last
//   config    cfg_we                 cfg_data (match_label)
//
// Key words and clears are accepted in idle. End of text is accepted, then
// drains the window at one word per cycle while the output is free, and
// returns to idle once the window is empty.
// A text word is accepted, then for each stored key the length is read from
// the length memory and checked, and each compared token is read from the
// key memory and then compared (single read port), then the due words are
// emitted while the output is free, and idle follows once nothing is due.
// Reset clears the key count, the window fill and the output valid; key
// memory contents are not cleared, only committed keys are ever read.
// A stalled output holds its word; the next input word is still taken unless a
// window word is due, and the drain waits until the output register is free.
module token_phrase_dictionary_marker_core import tpdm_pkg::*; #(
  parameter int MAX_KEYS = 64,
  parameter int MAX_SPAN = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [30:0]        token_value,
  input  logic               key_end,
  input  logic               token_missing,
  input  logic signed [31:0] prior_label,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] position_label,
  output logic               text_last,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_data
);

  tpdm_cmd_t    cmd;
  tpdm_status_t status;

  // sequence key scan, compare and window drain
  tpdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold keys, window and output word
  tpdm_dp #(
    .MAX_KEYS (MAX_KEYS),
    .MAX_SPAN (MAX_SPAN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .opcode         (opcode),
    .token_value    (token_value),
    .key_end        (key_end),
    .token_missing  (token_missing),
    .prior_label    (prior_label),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .position_label (position_label),
    .text_last      (text_last)
  );

endmodule

// ===== design/tpdm_ctrl.sv =====
// Controller state machine of the phrase-dictionary marker.
// Depends on tpdm_pkg; drives tpdm_dp through command/status structs.
module tpdm_ctrl import tpdm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   opcode,
  output logic         in_ready,
  input  tpdm_status_t status,
  output tpdm_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LEN_RD  = 7'b0000010,
    S_LEN_CHK = 7'b0000100,
    S_TOK_RD  = 7'b0001000,
    S_TOK_CHK = 7'b0010000,
    S_POP     = 7'b0100000,
    S_FLUSH   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (opcode_t'(opcode))
            OP_TEXT: begin
              cmd.key_first = 1'b1;
              state_next = status.has_keys ? S_LEN_RD : S_POP;
            end
            OP_END:  state_next = S_FLUSH;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LEN_RD: state_next = S_LEN_CHK;
      S_LEN_CHK: begin
        if (status.len_skip) begin
          if (status.key_last) begin
            state_next = S_POP;
          end else begin
            cmd.key_next = 1'b1;
            state_next = S_LEN_RD;
          end
        end else begin
          cmd.tok_first = 1'b1;
          state_next = S_TOK_RD;
        end
      end
      S_TOK_RD: state_next = S_TOK_CHK;
      S_TOK_CHK: begin
        if (status.tok_last) begin
          cmd.tok_hit = 1'b1;
          if (status.key_last) begin
            state_next = S_POP;
          end else begin
            cmd.key_next = 1'b1;
            state_next = S_LEN_RD;
          end
        end else begin
          cmd.tok_next = 1'b1;
          state_next = S_TOK_RD;
        end
      end
      S_POP: begin
        if (status.pop_needed) begin
          cmd.pop = status.out_free;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status.flush_needed) begin
          cmd.pop = status.out_free;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a key step and a pop never share a cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !(cmd.tok_hit || cmd.key_next || cmd.accept))
    else $error("pop overlaps match work");
  // compare always follows a registered read
  assert property (@(posedge clk) disable iff (rst)
    state == S_TOK_CHK |-> $past(state) == S_TOK_RD)
    else $error("compare without read");
  // no word taken outside idle
  assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> state == S_IDLE && in_valid)
    else $error("accept outside idle");

endmodule

// ===== design/tpdm_dp.sv =====
// Datapath of the phrase-dictionary marker: key memories, token window,
// match compare and output register. Depends on tpdm_pkg.
module tpdm_dp import tpdm_pkg::*; #(
  parameter int MAX_KEYS = 64,
  parameter int MAX_SPAN = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  tpdm_cmd_t           cmd,
  output tpdm_status_t        status,
  input  logic [1:0]          opcode,
  input  logic [30:0]         token_value,
  input  logic                key_end,
  input  logic                token_missing,
  input  logic signed [31:0]  prior_label,
  input  logic                cfg_we,
  input  logic signed [31:0]  cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  position_label,
  output logic                text_last
);

  localparam int WD    = MAX_SPAN + 1;
  localparam int FW    = $clog2(MAX_SPAN + 2);
  localparam int LW    = $clog2(MAX_SPAN + 1);
  localparam int WIW   = $clog2(WD);
  localparam int KW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int DEPTH = MAX_KEYS * MAX_SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [30:0]        key_store [DEPTH];
  logic [LW-1:0]      key_len   [MAX_KEYS];
  logic [30:0]        tok_q;
  logic [LW-1:0]      len_q;

  logic [CW-1:0]      key_count;
  logic [LW-1:0]      loading_length;
  logic               loading_bad;
  logic [LW-1:0]      longest_key;
  logic signed [31:0] match_label;

  logic [30:0]        win_tok [WD];
  logic signed [31:0] win_lab [WD];
  logic               win_hit [WD];
  logic [FW-1:0]      fill;

  logic [KW-1:0]      k;
  logic [LW-1:0]      j;
  logic               same;

  logic [AW-1:0]      rd_addr, wr_addr;
  logic [FW-1:0]      start_full, idx_full;
  logic [WIW-1:0]     start_idx, cmp_idx;
  logic               eq;
  logic [LW-1:0]      keep;
  logic               key_room, len_room, bad_n;
  logic [LW-1:0]      len_inc;

  assign rd_addr    = AW'(k) * AW'(MAX_SPAN) + AW'(j);
  assign wr_addr    = AW'(key_count[KW-1:0]) * AW'(MAX_SPAN) + AW'(loading_length);
  assign start_full = fill - FW'(len_q);
  assign idx_full   = start_full + FW'(j);
  assign start_idx  = start_full[WIW-1:0];
  assign cmp_idx    = idx_full[WIW-1:0];
  assign eq         = (tok_q == win_tok[cmp_idx]);
  assign keep       = (longest_key > LW'(1)) ? longest_key - LW'(1) : LW'(1);
  assign key_room   = (key_count < CW'(MAX_KEYS));
  assign len_room   = (loading_length < LW'(MAX_SPAN));
  assign bad_n      = loading_bad | token_missing | !len_room;
  assign len_inc    = len_room ? loading_length + LW'(1) : loading_length;

  always_comb begin
    status.has_keys     = (key_count != '0);
    status.len_skip     = (len_q == '0) || (FW'(len_q) > fill);
    status.key_last     = (CW'(k) + CW'(1) == key_count);
    status.tok_last     = (j + LW'(1) == len_q);
    status.pop_needed   = (fill > FW'(keep));
    status.flush_needed = (fill != '0);
    status.out_free     = !out_valid || out_ready;
  end

  // key memories: registered reads, writes while loading
  always_ff @(posedge clk) begin
    tok_q <= key_store[rd_addr];
    len_q <= key_len[k];
    if (cmd.accept && opcode_t'(opcode) == OP_KEY) begin
      if (len_room && key_room) begin
        key_store[wr_addr] <= token_value;
      end
      if (key_end && !bad_n && key_room && len_inc != '0) begin
        key_len[key_count[KW-1:0]] <= len_inc;
      end
    end
  end

  // key table control
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count      <= '0;
      loading_length <= '0;
      loading_bad    <= 1'b0;
      longest_key    <= '0;
    end else if (cmd.accept && opcode_t'(opcode) == OP_CLEAR) begin
      key_count      <= '0;
      loading_length <= '0;
      loading_bad    <= 1'b0;
      longest_key    <= '0;
    end else if (cmd.accept && opcode_t'(opcode) == OP_KEY) begin
      if (key_end) begin
        if (!bad_n && key_room && len_inc != '0) begin
          key_count <= key_count + CW'(1);
          if (len_inc > longest_key) begin
            longest_key <= len_inc;
          end
        end
        loading_length <= '0;
        loading_bad    <= 1'b0;
      end else begin
        loading_length <= len_inc;
        loading_bad    <= bad_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_label <= 32'sd1;
    end else if (cfg_we) begin
      match_label <= cfg_data;
    end
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (cmd.key_first) begin
      k <= '0;
    end else if (cmd.key_next) begin
      k <= k + KW'(1);
    end
    if (cmd.tok_first) begin
      j    <= '0;
      same <= 1'b1;
    end else if (cmd.tok_next) begin
      j    <= j + LW'(1);
      same <= same & eq;
    end
  end

  // token window
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < WD; i++) begin
        win_hit[i] <= 1'b0;
      end
    end else if (cmd.accept && opcode_t'(opcode) == OP_TEXT) begin
      win_tok[fill[WIW-1:0]] <= token_value;
      win_lab[fill[WIW-1:0]] <= prior_label;
      win_hit[fill[WIW-1:0]] <= 1'b0;
      fill <= fill + FW'(1);
    end else if (cmd.tok_hit) begin
      if (same && eq) begin
        win_hit[start_idx] <= 1'b1;
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < WD - 1; i++) begin
        win_tok[i] <= win_tok[i + 1];
        win_lab[i] <= win_lab[i + 1];
        win_hit[i] <= win_hit[i + 1];
      end
      fill <= fill - FW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      position_label <= win_hit[0] ? match_label : win_lab[0];
      text_last      <= (fill == FW'(1)) && !status.pop_needed;
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= FW'(MAX_SPAN))
    else $error("window overflow");
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> status.out_free && fill != '0)
    else $error("pop into a full output register or empty window");
  assert property (@(posedge clk) disable iff (rst) cmd.pop |=> out_valid)
    else $error("popped word not presented");

endmodule
